// ===== hw/rtl/lrs_pkg.sv =====
`timescale 1ns / 1ps

package lrs_pkg;

  localparam int KIND_W = 3;
  localparam int ROW_W = 6;
  localparam int COL_W = 6;
  localparam int VALUE_W = 32;
  localparam int GRID_LAST_DEF = 63;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE     = 3'd0,
    KIND_READ      = 3'd1,
    KIND_SWEEP_COL = 3'd2,
    KIND_SWEEP_ROW = 3'd3,
    KIND_FILL      = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    NB_CENTER = 3'd0,
    NB_DOWN   = 3'd1,
    NB_UP     = 3'd2,
    NB_LEFT   = 3'd3,
    NB_RIGHT  = 3'd4
  } nb_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SWEEP,
    ST_SWEEP_DRAIN,
    ST_FILL,
    ST_FILL_DRAIN
  } state_e;

endpackage

// ===== hw/rtl/lrs_ram.sv =====
`timescale 1ns / 1ps

module lrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hw/rtl/laplace_relaxation_sweep.sv =====
`timescale 1ns / 1ps

// Grid of (GRID_LAST+1) squared Q16.16 potentials in one memory with a single read port.
// A cell write returns its result in the cycle after start; a cell read passes through
// ST_READ before its result. A sweep reads the center and four neighbors of each of its
// SIDE*GRID_LAST cells, one memory read per cycle; the updated cell is written back, when
// its old value is nonzero, while the next cell's reads begin. A fill reads one cell per
// cycle; when the start row is GRID_LAST or beyond it returns its result in the cycle after
// start, as a write does. Each item yields exactly one result on done_o, one cycle
// wide; the receiver cannot hold it off, and busy is low again in that same cycle.

module laplace_relaxation_sweep #(
  parameter int GRID_LAST = lrs_pkg::GRID_LAST_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic        [lrs_pkg::KIND_W-1:0]  kind_i,
  input  logic        [lrs_pkg::ROW_W-1:0]   row_i,
  input  logic        [lrs_pkg::COL_W-1:0]   col_i,
  input  logic signed [lrs_pkg::VALUE_W-1:0] value_i,
  output logic                               done_o,
  output logic        [lrs_pkg::KIND_W-1:0]  done_kind_o,
  output logic signed [lrs_pkg::VALUE_W-1:0] read_value_o
);

  import lrs_pkg::*;

  localparam int SIDE = GRID_LAST + 1;
  localparam int CW = $clog2(SIDE);
  localparam int DEPTH = SIDE * SIDE;
  localparam int AW = $clog2(DEPTH);
  localparam int SUM_W = VALUE_W + 2;
  localparam logic [CW-1:0] LAST = CW'(GRID_LAST);
  localparam logic [CW-1:0] LAST_ROW = CW'(GRID_LAST - 1);

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return AW'(r) * AW'(SIDE) + AW'(c);
  endfunction

  state_e              state_q, state_d;
  nb_e                 ph_q, ph_d;
  nb_e                 tag_q, tag_d;
  logic                tag_vld_q, tag_vld_d;
  logic                pend_q, pend_d;
  logic [KIND_W-1:0]   kind_q, kind_d;
  logic [CW-1:0]       r_q, r_d;
  logic [CW-1:0]       c_q, c_d;
  logic [VALUE_W-1:0]  value_q, value_d;
  logic [AW-1:0]       ctr_addr_q, ctr_addr_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic                ctr_nz_q, ctr_nz_d;
  logic                inside_q, inside_d;
  logic                done_q, done_d;
  logic [KIND_W-1:0]   done_kind_q, done_kind_d;
  logic [VALUE_W-1:0]  read_value_q, read_value_d;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [VALUE_W-1:0]  ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [VALUE_W-1:0]  ram_rdata;

  logic                in_inside;
  logic [CW-1:0]       in_row;
  logic [CW-1:0]       in_col;
  logic [SUM_W-1:0]    addend;
  logic [SUM_W-1:0]    sum_full;
  logic [CW-1:0]       nb_r;
  logic [CW-1:0]       nb_c;
  logic                nb_vld;
  logic                last_cell;

  lrs_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH)
  ) u_grid (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_inside = (32'(row_i) <= 32'(GRID_LAST)) && (32'(col_i) <= 32'(GRID_LAST));
  assign in_row = CW'(row_i);
  assign in_col = CW'(col_i);
  assign addend = tag_vld_q ? {{(SUM_W - VALUE_W){ram_rdata[VALUE_W-1]}}, ram_rdata}
                            : '0;
  assign sum_full = sum_q + addend;
  assign last_cell = (r_q == '0) && (c_q == LAST);

  always_comb begin
    nb_r = r_q;
    nb_c = c_q;
    nb_vld = 1'b1;
    case (ph_q)
      NB_CENTER: begin
        nb_vld = 1'b1;
      end
      NB_DOWN: begin
        nb_r = r_q + 1'b1;
      end
      NB_UP: begin
        nb_r = r_q - 1'b1;
        nb_vld = (r_q != '0);
      end
      NB_LEFT: begin
        nb_c = c_q - 1'b1;
        nb_vld = (c_q != '0);
      end
      NB_RIGHT: begin
        nb_c = c_q + 1'b1;
        nb_vld = (c_q != LAST);
      end
      default: begin
        nb_vld = 1'b0;
      end
    endcase
    if (!nb_vld) begin
      nb_r = r_q;
      nb_c = c_q;
    end
  end

  always_comb begin
    state_d = state_q;
    ph_d = ph_q;
    tag_d = tag_q;
    tag_vld_d = tag_vld_q;
    pend_d = 1'b0;
    kind_d = kind_q;
    r_d = r_q;
    c_d = c_q;
    value_d = value_q;
    ctr_addr_d = ctr_addr_q;
    sum_d = sum_q;
    ctr_nz_d = ctr_nz_q;
    inside_d = inside_q;
    done_d = 1'b0;
    done_kind_d = done_kind_q;
    read_value_d = read_value_q;
    ram_we = 1'b0;
    ram_waddr = ctr_addr_q;
    ram_wdata = value_q;
    ram_raddr = cell_addr(r_q, c_q);

    if ((state_q == ST_SWEEP || state_q == ST_SWEEP_DRAIN) && pend_q) begin
      case (tag_q)
        NB_CENTER: begin
          ctr_nz_d = (ram_rdata != '0);
          sum_d = '0;
        end
        NB_RIGHT: begin
          ram_we = ctr_nz_q;
          ram_wdata = sum_full[SUM_W-1:2];
        end
        default: begin
          sum_d = sum_full;
        end
      endcase
    end
    if ((state_q == ST_FILL || state_q == ST_FILL_DRAIN) && pend_q) begin
      ram_we = (ram_rdata != '0);
    end

    case (state_q)
      ST_IDLE: begin
        ram_raddr = in_inside ? cell_addr(in_row, in_col) : '0;
        if (start) begin
          kind_d = kind_i;
          value_d = value_i;
          inside_d = in_inside;
          case (kind_i)
            KIND_WRITE: begin
              ram_we = in_inside;
              ram_waddr = in_inside ? cell_addr(in_row, in_col) : '0;
              ram_wdata = value_i;
              done_d = 1'b1;
              done_kind_d = kind_i;
              read_value_d = '0;
            end
            KIND_READ: begin
              state_d = ST_READ;
            end
            KIND_SWEEP_COL, KIND_SWEEP_ROW: begin
              state_d = ST_SWEEP;
              ph_d = NB_CENTER;
              r_d = LAST_ROW;
              c_d = '0;
            end
            KIND_FILL: begin
              if (32'(row_i) >= 32'(GRID_LAST)) begin
                done_d = 1'b1;
                done_kind_d = kind_i;
                read_value_d = '0;
              end else begin
                state_d = ST_FILL;
                r_d = in_row;
                c_d = '0;
              end
            end
            default: begin
              done_d = 1'b1;
              done_kind_d = kind_i;
              read_value_d = '0;
            end
          endcase
        end
      end
      ST_READ: begin
        done_d = 1'b1;
        done_kind_d = kind_q;
        read_value_d = inside_q ? ram_rdata : '0;
        state_d = ST_IDLE;
      end
      ST_SWEEP: begin
        ram_raddr = cell_addr(nb_r, nb_c);
        pend_d = 1'b1;
        tag_d = ph_q;
        tag_vld_d = nb_vld;
        if (ph_q == NB_CENTER) begin
          ctr_addr_d = cell_addr(r_q, c_q);
        end
        case (ph_q)
          NB_CENTER: ph_d = NB_DOWN;
          NB_DOWN:   ph_d = NB_UP;
          NB_UP:     ph_d = NB_LEFT;
          NB_LEFT:   ph_d = NB_RIGHT;
          default:   ph_d = NB_CENTER;
        endcase
        if (ph_q == NB_RIGHT) begin
          if (last_cell) begin
            state_d = ST_SWEEP_DRAIN;
          end else if (kind_q == KIND_SWEEP_COL) begin
            if (r_q == '0) begin
              r_d = LAST_ROW;
              c_d = c_q + 1'b1;
            end else begin
              r_d = r_q - 1'b1;
            end
          end else begin
            if (c_q == LAST) begin
              c_d = '0;
              r_d = r_q - 1'b1;
            end else begin
              c_d = c_q + 1'b1;
            end
          end
        end
      end
      ST_SWEEP_DRAIN: begin
        done_d = 1'b1;
        done_kind_d = kind_q;
        read_value_d = '0;
        state_d = ST_IDLE;
      end
      ST_FILL: begin
        ram_raddr = cell_addr(r_q, c_q);
        ctr_addr_d = cell_addr(r_q, c_q);
        pend_d = 1'b1;
        if (c_q == LAST) begin
          c_d = '0;
          if (r_q == LAST_ROW) begin
            state_d = ST_FILL_DRAIN;
          end else begin
            r_d = r_q + 1'b1;
          end
        end else begin
          c_d = c_q + 1'b1;
        end
      end
      ST_FILL_DRAIN: begin
        done_d = 1'b1;
        done_kind_d = kind_q;
        read_value_d = '0;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ph_q <= NB_CENTER;
      pend_q <= 1'b0;
      r_q <= '0;
      c_q <= '0;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q <= ph_d;
      pend_q <= pend_d;
      r_q <= r_d;
      c_q <= c_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
    tag_vld_q <= tag_vld_d;
    kind_q <= kind_d;
    value_q <= value_d;
    ctr_addr_q <= ctr_addr_d;
    sum_q <= sum_d;
    ctr_nz_q <= ctr_nz_d;
    inside_q <= inside_d;
    done_kind_q <= done_kind_d;
    read_value_q <= read_value_d;
  end

  assign busy = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign done_kind_o = done_kind_q;
  assign read_value_o = read_value_q;

endmodule
